/* design/lc3_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lc3_pkg
// Shared types, constants and helpers for the LC-3 instruction core.
// ----------------------------------------------------------------------------
package lc3_pkg;

    localparam int MEM_WORDS = 65536;          // power of two, 1024..65536
    localparam int MEM_AW    = $clog2(MEM_WORDS);

    localparam logic [15:0] PC_RESET  = 16'h3000;
    localparam logic [15:0] KBSR_ADDR = 16'hFE00;
    localparam logic [15:0] KBDR_ADDR = 16'hFE02;
    localparam logic [15:0] KBSR_READY = 16'h8000;

    localparam logic [2:0] FLAG_P = 3'b001;
    localparam logic [2:0] FLAG_Z = 3'b010;
    localparam logic [2:0] FLAG_N = 3'b100;

    localparam logic [3:0] OP_BR   = 4'h0;
    localparam logic [3:0] OP_ADD  = 4'h1;
    localparam logic [3:0] OP_LD   = 4'h2;
    localparam logic [3:0] OP_ST   = 4'h3;
    localparam logic [3:0] OP_JSR  = 4'h4;
    localparam logic [3:0] OP_AND  = 4'h5;
    localparam logic [3:0] OP_LDR  = 4'h6;
    localparam logic [3:0] OP_STR  = 4'h7;
    localparam logic [3:0] OP_NOT  = 4'h9;
    localparam logic [3:0] OP_LDI  = 4'hA;
    localparam logic [3:0] OP_STI  = 4'hB;
    localparam logic [3:0] OP_JMP  = 4'hC;
    localparam logic [3:0] OP_LEA  = 4'hE;
    localparam logic [3:0] OP_TRAP = 4'hF;

    localparam logic [7:0] VEC_GETC  = 8'h20;
    localparam logic [7:0] VEC_OUT   = 8'h21;
    localparam logic [7:0] VEC_PUTS  = 8'h22;
    localparam logic [7:0] VEC_IN    = 8'h23;
    localparam logic [7:0] VEC_PUTSP = 8'h24;
    localparam logic [7:0] VEC_HALT  = 8'h25;

    localparam logic [1:0] STR_IDLE  = 2'd0;
    localparam logic [1:0] STR_PUTS  = 2'd1;
    localparam logic [1:0] STR_PUTSP = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_LOAD, S_FETCH_RD, S_FETCH_WT, S_EXEC,
        S_MEM1_RD, S_MEM1_WT, S_MEM2_RD, S_MEM2_WT, S_FINISH,
        S_KB_SR, S_KB_DR, S_STR_RD, S_STR_WT, S_RESP
    } state_t;

    typedef enum logic [3:0] {
        ACT_NONE, ACT_ACCEPT, ACT_LOAD, ACT_FETCH_RD, ACT_FETCH_WT, ACT_EXEC,
        ACT_MEM1_RD, ACT_MEM1_WT, ACT_MEM2_RD, ACT_MEM2_WT, ACT_FINISH,
        ACT_KB_SR, ACT_KB_DR, ACT_STR_RD, ACT_STR_WT
    } act_t;

    typedef struct packed {
        act_t act;
    } ctrl_cmd_t;

    typedef struct packed {
        logic mode;        // latched request: 1 = step
        logic stopped;     // halted or faulted
        logic str_busy;    // string output in progress
        logic is_kb;       // last read hit the keyboard status word
        logic key_valid;
        logic is_load;     // LD, LDR, LDI
        logic is_ldi;
        logic is_sti;
        logic is_store;    // ST, STR
        logic is_str_trap; // PUTS, PUTSP
    } dp_status_t;

    function automatic logic [2:0] flags_of(input logic [15:0] v);
        if (v == 16'h0000)
            return FLAG_Z;
        else if (v[15])
            return FLAG_N;
        else
            return FLAG_P;
    endfunction

endpackage
`default_nettype wire

/* design/lc3_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lc3_ctrl
// Sequencer: load, fetch, execute, memory phases, keyboard side writes, string output, response.
// ----------------------------------------------------------------------------
module lc3_ctrl
    import lc3_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  wire logic       out_stall,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        unique case (state_reg)
            S_IDLE:     if (in_valid) state_next = S_DISPATCH;
            S_DISPATCH:
            begin
                if (!status.mode)
                    state_next = S_LOAD;
                else if (status.stopped)
                    state_next = S_RESP;
                else if (status.str_busy)
                    state_next = S_STR_RD;
                else
                    state_next = S_FETCH_RD;
            end
            S_LOAD:     state_next = S_RESP;
            S_FETCH_RD: state_next = S_FETCH_WT;
            S_FETCH_WT:
            begin
                ret_next   = S_EXEC;
                state_next = status.is_kb ? S_KB_SR : S_EXEC;
            end
            S_EXEC:
            begin
                if (status.is_load || status.is_sti)
                    state_next = S_MEM1_RD;
                else if (status.is_store)
                    state_next = S_FINISH;
                else if (status.is_str_trap)
                    state_next = S_STR_RD;
                else
                    state_next = S_RESP;
            end
            S_MEM1_RD:  state_next = S_MEM1_WT;
            S_MEM1_WT:
            begin
                ret_next   = status.is_ldi ? S_MEM2_RD : S_FINISH;
                state_next = status.is_kb ? S_KB_SR : ret_next;
            end
            S_MEM2_RD:  state_next = S_MEM2_WT;
            S_MEM2_WT:
            begin
                ret_next   = S_FINISH;
                state_next = status.is_kb ? S_KB_SR : S_FINISH;
            end
            S_KB_SR:    state_next = status.key_valid ? S_KB_DR : ret_reg;
            S_KB_DR:    state_next = ret_reg;
            S_FINISH:   state_next = S_RESP;
            S_STR_RD:   state_next = S_STR_WT;
            S_STR_WT:   state_next = S_RESP;
            S_RESP:     if (!out_stall) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall  = (state_reg != S_IDLE);
        out_valid = (state_reg == S_RESP);
        cmd.act   = ACT_NONE;
        unique case (state_reg)
            S_IDLE:     cmd.act = in_valid ? ACT_ACCEPT : ACT_NONE;
            S_LOAD:     cmd.act = ACT_LOAD;
            S_FETCH_RD: cmd.act = ACT_FETCH_RD;
            S_FETCH_WT: cmd.act = ACT_FETCH_WT;
            S_EXEC:     cmd.act = ACT_EXEC;
            S_MEM1_RD:  cmd.act = ACT_MEM1_RD;
            S_MEM1_WT:  cmd.act = ACT_MEM1_WT;
            S_MEM2_RD:  cmd.act = ACT_MEM2_RD;
            S_MEM2_WT:  cmd.act = ACT_MEM2_WT;
            S_FINISH:   cmd.act = ACT_FINISH;
            S_KB_SR:    cmd.act = ACT_KB_SR;
            S_KB_DR:    cmd.act = ACT_KB_DR;
            S_STR_RD:   cmd.act = ACT_STR_RD;
            S_STR_WT:   cmd.act = ACT_STR_WT;
            default:    cmd.act = ACT_NONE;
        endcase
    end

    a_kbdr_after_kbsr: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_KB_DR |-> $past(state_reg) == S_KB_SR)
        else $error("keyboard data write without status write");

    a_exec_after_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC |-> $past(state_reg) == S_FETCH_WT
            || $past(state_reg) == S_KB_SR || $past(state_reg) == S_KB_DR)
        else $error("execute entered without a fetch");

    a_resp_holds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RESP && out_stall |=> state_reg == S_RESP)
        else $error("response dropped while stalled");

endmodule
`default_nettype wire

/* design/lc3_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lc3_datapath
// Main memory, register file, PC, flags, string state and result registers.
// ----------------------------------------------------------------------------
module lc3_datapath
    import lc3_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire ctrl_cmd_t   cmd,
    output dp_status_t       status,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        mode,
    input  wire logic [15:0] load_address,
    input  wire logic [15:0] load_word,
    input  wire logic        key_valid,
    input  wire logic [7:0]  key_char,
    output logic             char_valid,
    output logic [7:0]       char_out,
    output logic             retired,
    output logic             waiting_key,
    output logic             stopped,
    output logic             fault,
    output logic [15:0]      pc_now
);

    logic [15:0] mem [MEM_WORDS];
    logic [15:0] rdata_reg;
    logic [15:0] mar_reg;

    logic [15:0] rf_reg [8];
    logic [15:0] pc_reg, ir_reg, mdr_reg, sptr_reg;
    logic [2:0]  flags_reg;
    logic        halted_reg, fault_reg, hbp_reg;
    logic [1:0]  smode_reg;
    logic        mode_reg, kv_reg;
    logic [15:0] laddr_reg, lword_reg;
    logic [7:0]  kc_reg;
    logic        cv_reg, ret_reg, wait_reg;
    logic [7:0]  ch_reg;

    logic [3:0]  op;
    logic [2:0]  dr, sr;
    logic [7:0]  vec;
    logic [15:0] off9, off6, off11, imm5, sr_val, dr_val, op2, ea_pc, ea_base;
    logic [15:0] alu_res, rd_val, raddr, waddr, wdata, kbsr_val;
    logic        we, key_trap, str_trap, need_wait;

    assign op      = ir_reg[15:12];
    assign dr      = ir_reg[11:9];
    assign sr      = ir_reg[8:6];
    assign vec     = ir_reg[7:0];
    assign off9    = {{7{ir_reg[8]}}, ir_reg[8:0]};
    assign off6    = {{10{ir_reg[5]}}, ir_reg[5:0]};
    assign off11   = {{5{ir_reg[10]}}, ir_reg[10:0]};
    assign imm5    = {{11{ir_reg[4]}}, ir_reg[4:0]};
    assign sr_val  = rf_reg[sr];
    assign dr_val  = rf_reg[dr];
    assign op2     = ir_reg[5] ? imm5 : rf_reg[ir_reg[2:0]];
    assign ea_pc   = pc_reg + off9;
    assign ea_base = sr_val + off6;
    assign kbsr_val = kv_reg ? KBSR_READY : 16'h0000;
    // keyboard status read returns the value it is about to be overwritten with
    assign rd_val  = (mar_reg == KBSR_ADDR) ? kbsr_val : rdata_reg;

    assign key_trap  = (op == OP_TRAP) && (vec == VEC_GETC || vec == VEC_IN);
    assign str_trap  = (op == OP_TRAP) && (vec == VEC_PUTS || vec == VEC_PUTSP);
    assign need_wait = key_trap && !kv_reg;

    always_comb
    begin
        unique case (op)
            OP_ADD:  alu_res = sr_val + op2;
            OP_AND:  alu_res = sr_val & op2;
            OP_NOT:  alu_res = ~sr_val;
            default: alu_res = ea_pc;   // LEA
        endcase
    end

    always_comb
    begin
        unique case (cmd.act)
            ACT_FETCH_RD: raddr = pc_reg;
            ACT_MEM1_RD:  raddr = (op == OP_LDR) ? ea_base : ea_pc;
            ACT_MEM2_RD:  raddr = mdr_reg;
            default:      raddr = sptr_reg;
        endcase
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = laddr_reg;
        wdata = lword_reg;
        unique case (cmd.act)
            ACT_LOAD:  we = 1'b1;
            ACT_KB_SR:
            begin
                we    = 1'b1;
                waddr = KBSR_ADDR;
                wdata = kbsr_val;
            end
            ACT_KB_DR:
            begin
                we    = 1'b1;
                waddr = KBDR_ADDR;
                wdata = {8'h00, kc_reg};
            end
            ACT_FINISH:
            begin
                we    = (op == OP_ST) || (op == OP_STR) || (op == OP_STI);
                waddr = (op == OP_STR) ? ea_base : ((op == OP_STI) ? mdr_reg : ea_pc);
                wdata = dr_val;
            end
            default: we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr[MEM_AW-1:0]] <= wdata;
        rdata_reg <= mem[raddr[MEM_AW-1:0]];
        mar_reg   <= raddr;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.act == ACT_ACCEPT)
        begin
            mode_reg  <= mode;
            laddr_reg <= load_address;
            lword_reg <= load_word;
            kv_reg    <= key_valid;
            kc_reg    <= key_char;
        end
        if (cmd.act == ACT_FETCH_WT)
            ir_reg <= rd_val;
        if (cmd.act == ACT_MEM1_WT || cmd.act == ACT_MEM2_WT)
            mdr_reg <= rd_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                rf_reg[i] <= 16'h0000;
            pc_reg     <= PC_RESET;
            flags_reg  <= FLAG_Z;
            halted_reg <= 1'b0;
            fault_reg  <= 1'b0;
            sptr_reg   <= 16'h0000;
            smode_reg  <= STR_IDLE;
            hbp_reg    <= 1'b0;
            cv_reg     <= 1'b0;
            ch_reg     <= 8'h00;
            ret_reg    <= 1'b0;
            wait_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                pc_reg <= cfg_wr_data;
            unique case (cmd.act)
                ACT_ACCEPT:
                begin
                    cv_reg   <= 1'b0;
                    ch_reg   <= 8'h00;
                    ret_reg  <= 1'b0;
                    wait_reg <= 1'b0;
                end
                ACT_FETCH_WT: pc_reg <= pc_reg + 16'd1;
                ACT_EXEC:
                begin
                    ret_reg <= 1'b1;
                    unique case (op)
                        OP_BR:
                            if ((dr & flags_reg) != 3'b000)
                                pc_reg <= ea_pc;
                        OP_ADD, OP_AND, OP_NOT, OP_LEA:
                        begin
                            rf_reg[dr] <= alu_res;
                            flags_reg  <= flags_of(alu_res);
                        end
                        OP_JMP: pc_reg <= sr_val;
                        OP_JSR:
                        begin
                            rf_reg[7] <= pc_reg;
                            pc_reg    <= ir_reg[11] ? pc_reg + off11 : sr_val;
                        end
                        OP_LD, OP_ST, OP_LDR, OP_STR, OP_LDI, OP_STI: ;
                        OP_TRAP:
                        begin
                            if (need_wait)
                            begin
                                wait_reg <= 1'b1;
                                ret_reg  <= 1'b0;
                                pc_reg   <= pc_reg - 16'd1;
                            end
                            else
                            begin
                                rf_reg[7] <= pc_reg;
                                if (key_trap)
                                begin
                                    rf_reg[0] <= {8'h00, kc_reg};
                                    flags_reg <= flags_of({8'h00, kc_reg});
                                    if (vec == VEC_IN)
                                    begin
                                        cv_reg <= 1'b1;
                                        ch_reg <= kc_reg;
                                    end
                                end
                                else if (vec == VEC_OUT)
                                begin
                                    cv_reg <= 1'b1;
                                    ch_reg <= rf_reg[0][7:0];
                                end
                                else if (str_trap)
                                begin
                                    smode_reg <= (vec == VEC_PUTS) ? STR_PUTS : STR_PUTSP;
                                    sptr_reg  <= rf_reg[0];
                                    hbp_reg   <= 1'b0;
                                end
                                else if (vec == VEC_HALT)
                                    halted_reg <= 1'b1;
                            end
                        end
                        default:
                        begin
                            fault_reg <= 1'b1;
                            ret_reg   <= 1'b0;
                        end
                    endcase
                end
                ACT_FINISH:
                    if (op == OP_LD || op == OP_LDR || op == OP_LDI)
                    begin
                        rf_reg[dr] <= mdr_reg;
                        flags_reg  <= flags_of(mdr_reg);
                    end
                ACT_STR_WT:
                begin
                    // string element reads the raw word, no keyboard side effect
                    ret_reg <= 1'b1;
                    if (smode_reg == STR_PUTSP && hbp_reg)
                    begin
                        cv_reg   <= 1'b1;
                        ch_reg   <= rdata_reg[15:8];
                        hbp_reg  <= 1'b0;
                        sptr_reg <= sptr_reg + 16'd1;
                    end
                    else if (rdata_reg == 16'h0000)
                    begin
                        smode_reg <= STR_IDLE;
                        hbp_reg   <= 1'b0;
                    end
                    else
                    begin
                        cv_reg <= 1'b1;
                        ch_reg <= rdata_reg[7:0];
                        if (smode_reg == STR_PUTSP && rdata_reg[15:8] != 8'h00)
                            hbp_reg <= 1'b1;
                        else
                            sptr_reg <= sptr_reg + 16'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        status.mode        = mode_reg;
        status.stopped     = halted_reg | fault_reg;
        status.str_busy    = (smode_reg != STR_IDLE);
        status.is_kb       = (mar_reg == KBSR_ADDR);
        status.key_valid   = kv_reg;
        status.is_load     = (op == OP_LD) || (op == OP_LDR) || (op == OP_LDI);
        status.is_ldi      = (op == OP_LDI);
        status.is_sti      = (op == OP_STI);
        status.is_store    = (op == OP_ST) || (op == OP_STR);
        status.is_str_trap = str_trap;
    end

    assign char_valid  = cv_reg;
    assign char_out    = ch_reg;
    assign retired     = ret_reg;
    assign waiting_key = wait_reg;
    assign stopped     = halted_reg;
    assign fault       = fault_reg;
    assign pc_now      = pc_reg;

endmodule
`default_nettype wire

/* design/lc3_instruction_core.sv */
// Sequence, accept to result taken: a load, or a step when stopped, goes straight
// to the response; a step otherwise reads a string character or runs an instruction
// (fetch, two dependent reads for LDI, a keyboard status write after a keyboard
// status read and a data write when a key is present). One request at a time, the
// next accepted in the cycle after the result is taken; output stalls hold the result.
// Reset: asynchronous, active low; PC = x3000, flags = Z, registers zero.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lc3_instruction_core
// LC-3 machine: memory load and single-step execution with character output.
// ----------------------------------------------------------------------------
module lc3_instruction_core
    import lc3_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        mode,
    input  wire logic [15:0] load_address,
    input  wire logic [15:0] load_word,
    input  wire logic        key_valid,
    input  wire logic [7:0]  key_char,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             char_valid,
    output logic [7:0]       char_out,
    output logic             retired,
    output logic             waiting_key,
    output logic             stopped,
    output logic             fault,
    output logic [15:0]      pc_now
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    lc3_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    lc3_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .mode         (mode),
        .load_address (load_address),
        .load_word    (load_word),
        .key_valid    (key_valid),
        .key_char     (key_char),
        .char_valid   (char_valid),
        .char_out     (char_out),
        .retired      (retired),
        .waiting_key  (waiting_key),
        .stopped      (stopped),
        .fault        (fault),
        .pc_now       (pc_now)
    );

endmodule
`default_nettype wire

/* tb/sv/lc3_instruction_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lc3_instruction_core_tb
// Self-checking bench: random LC-3 programs are loaded and single-stepped,
// every result is compared with an in-bench machine model.
// ----------------------------------------------------------------------------
module lc3_instruction_core_tb;
    import lc3_pkg::*;

    localparam logic [3:0] OP_RTI = 4'h8;
    localparam logic [3:0] OP_RES = 4'hD;

    typedef struct {
        bit        cv;
        bit [7:0]  ch;
        bit        ret;
        bit        wk;
        bit        stp;
        bit        flt;
        bit [15:0] pc;
    } step_result_t;

    class lc3_scoreboard;
        bit [15:0] mem [MEM_WORDS];
        bit        wr  [MEM_WORDS];
        bit [15:0] rf  [8];
        bit [15:0] pc;
        bit [2:0]  flags;
        bit        halted;
        bit        faulted;
        bit [15:0] sptr;
        bit [1:0]  smode;
        bit        hb;
        step_result_t pending_q[$];
        int        errors;

        function new();
            pc = PC_RESET;
            flags = FLAG_Z;
        endfunction

        function void configure(bit [15:0] v);
            pc = v;
        endfunction

        function bit [15:0] rd(bit [15:0] a, bit kv, bit [7:0] kc);
            if (a == KBSR_ADDR)
            begin
                mem[KBSR_ADDR] = kv ? KBSR_READY : 16'h0000;
                wr[KBSR_ADDR] = 1;
                if (kv)
                begin
                    mem[KBDR_ADDR] = {8'h00, kc};
                    wr[KBDR_ADDR] = 1;
                end
            end
            return mem[a];
        endfunction

        function void set_flags(bit [15:0] v);
            flags = flags_of(v);
        endfunction

        function void string_element(ref bit cv, ref bit [7:0] ch);
            bit [15:0] w;
            w = mem[sptr];
            if (smode == STR_PUTSP && hb)
            begin
                cv = 1;
                ch = w[15:8];
                hb = 0;
                sptr++;
                return;
            end
            if (w == 0)
            begin
                smode = STR_IDLE;
                hb = 0;
                return;
            end
            cv = 1;
            ch = w[7:0];
            if (smode == STR_PUTSP && w[15:8] != 0)
                hb = 1;
            else
                sptr++;
        endfunction

        function void note_input(bit m, bit [15:0] la, bit [15:0] lw, bit kv, bit [7:0] kc);
            step_result_t r;
            bit [15:0] inst, npc, t, opnd2, off9, off6;
            bit [2:0] dr, sr;
            bit [7:0] vec;
            r.cv = 0; r.ch = 0; r.ret = 0; r.wk = 0;
            if (!m)
            begin
                mem[la] = lw;
                wr[la] = 1;
            end
            else if (halted || faulted)
            begin
            end
            else if (smode != STR_IDLE)
            begin
                string_element(r.cv, r.ch);
                r.ret = 1;
            end
            else
            begin
                inst = rd(pc, kv, kc);
                npc = pc + 16'd1;
                dr = inst[11:9];
                sr = inst[8:6];
                off9 = {{7{inst[8]}}, inst[8:0]};
                off6 = {{10{inst[5]}}, inst[5:0]};
                opnd2 = inst[5] ? {{11{inst[4]}}, inst[4:0]} : rf[inst[2:0]];
                r.ret = 1;
                case (inst[15:12])
                    OP_BR:  if (inst[11:9] & flags) npc = npc + off9;
                    OP_ADD: begin rf[dr] = rf[sr] + opnd2; set_flags(rf[dr]); end
                    OP_AND: begin rf[dr] = rf[sr] & opnd2; set_flags(rf[dr]); end
                    OP_NOT: begin rf[dr] = ~rf[sr]; set_flags(rf[dr]); end
                    OP_JMP: npc = rf[sr];
                    OP_JSR:
                    begin
                        t = inst[11] ? npc + {{5{inst[10]}}, inst[10:0]} : rf[sr];
                        rf[7] = npc;
                        npc = t;
                    end
                    OP_LD:  begin rf[dr] = rd(npc + off9, kv, kc); set_flags(rf[dr]); end
                    OP_LDI:
                    begin
                        t = rd(npc + off9, kv, kc);
                        rf[dr] = rd(t, kv, kc);
                        set_flags(rf[dr]);
                    end
                    OP_LDR: begin rf[dr] = rd(rf[sr] + off6, kv, kc); set_flags(rf[dr]); end
                    OP_LEA: begin rf[dr] = npc + off9; set_flags(rf[dr]); end
                    OP_ST:  begin mem[npc + off9] = rf[dr]; wr[npc + off9] = 1; end
                    OP_STI:
                    begin
                        t = rd(npc + off9, kv, kc);
                        mem[t] = rf[dr];
                        wr[t] = 1;
                    end
                    OP_STR: begin mem[rf[sr] + off6] = rf[dr]; wr[rf[sr] + off6] = 1; end
                    OP_TRAP:
                    begin
                        vec = inst[7:0];
                        if ((vec == VEC_GETC || vec == VEC_IN) && !kv)
                        begin
                            r.wk = 1;
                            r.ret = 0;
                            npc = pc;
                        end
                        else
                        begin
                            rf[7] = npc;
                            if (vec == VEC_GETC || vec == VEC_IN)
                            begin
                                rf[0] = {8'h00, kc};
                                set_flags(rf[0]);
                                if (vec == VEC_IN)
                                begin
                                    r.cv = 1;
                                    r.ch = kc;
                                end
                            end
                            else if (vec == VEC_OUT)
                            begin
                                r.cv = 1;
                                r.ch = rf[0][7:0];
                            end
                            else if (vec == VEC_PUTS || vec == VEC_PUTSP)
                            begin
                                smode = (vec == VEC_PUTS) ? STR_PUTS : STR_PUTSP;
                                sptr = rf[0];
                                hb = 0;
                                string_element(r.cv, r.ch);
                            end
                            else if (vec == VEC_HALT)
                                halted = 1;
                        end
                    end
                    default:
                    begin
                        faulted = 1;
                        r.ret = 0;
                    end
                endcase
                pc = npc;
            end
            r.stp = halted;
            r.flt = faulted;
            r.pc = pc;
            pending_q.push_back(r);
        endfunction

        function void check(step_result_t a);
            step_result_t e;
            if (pending_q.size() == 0)
            begin
                $error("unexpected result, pc_now %h", a.pc);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (a.cv != e.cv)
                begin $error("char_valid exp %0d got %0d", e.cv, a.cv); errors++; end
            if (a.ch != e.ch)
                begin $error("char_out exp %h got %h", e.ch, a.ch); errors++; end
            if (a.ret != e.ret)
                begin $error("retired exp %0d got %0d", e.ret, a.ret); errors++; end
            if (a.wk != e.wk)
                begin $error("waiting_key exp %0d got %0d", e.wk, a.wk); errors++; end
            if (a.stp != e.stp)
                begin $error("stopped exp %0d got %0d", e.stp, a.stp); errors++; end
            if (a.flt != e.flt)
                begin $error("fault exp %0d got %0d", e.flt, a.flt); errors++; end
            if (a.pc != e.pc)
                begin $error("pc_now exp %h got %h", e.pc, a.pc); errors++; end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_wr_en = 0;
    logic [15:0] cfg_wr_data = '0;
    logic        in_valid = 0;
    logic        in_stall;
    logic        mode = 0;
    logic [15:0] load_address = '0;
    logic [15:0] load_word = '0;
    logic        key_valid = 0;
    logic [7:0]  key_char = '0;
    logic        out_valid;
    logic        out_stall = 0;
    logic        char_valid;
    logic [7:0]  char_out;
    logic        retired;
    logic        waiting_key;
    logic        stopped;
    logic        fault;
    logic [15:0] pc_now;

    lc3_scoreboard sb = new();
    bit        primed;
    bit        ending;
    bit [15:0] term_word;
    bit [15:0] directed_q[$] = '{16'h126F, 16'h1470, 16'h1642, 16'h58E0, 16'h9AFF, 16'h0E01,
                                 16'hE005, 16'h2D00, 16'h3E10, 16'h6A7F, 16'h7C40, 16'hA002,
                                 16'hB7FF, 16'h4802, 16'h40C0, 16'hC1C0, 16'hF021, 16'hF020,
                                 16'hF023, 16'hF022, 16'hF024, 16'hF0FF};
    int        burst_left;

    lc3_instruction_core dut (
        .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
        .load_address(load_address), .load_word(load_word),
        .key_valid(key_valid), .key_char(key_char),
        .out_valid(out_valid), .out_stall(out_stall),
        .char_valid(char_valid), .char_out(char_out), .retired(retired),
        .waiting_key(waiting_key), .stopped(stopped), .fault(fault), .pc_now(pc_now)
    );

    always #10 clk = ~clk;

    function automatic bit is_terminal(bit [15:0] w);
        return w[15:12] == OP_RTI || w[15:12] == OP_RES ||
               (w[15:12] == OP_TRAP && w[7:0] == VEC_HALT);
    endfunction

    function automatic bit [15:0] next_instruction();
        bit [3:0] ops[14] = '{OP_BR, OP_ADD, OP_LD, OP_ST, OP_JSR, OP_AND, OP_LDR,
                              OP_STR, OP_NOT, OP_LDI, OP_STI, OP_JMP, OP_LEA, OP_TRAP};
        bit [15:0] w;
        bit [7:0]  vec;
        if (directed_q.size() != 0)
            return directed_q.pop_front();
        w = 16'($urandom);
        w[15:12] = ops[$urandom_range(0, 13)];
        if (w[15:12] == OP_TRAP)
        begin
            if ($urandom_range(0, 9) < 8)
                vec = VEC_GETC + 8'($urandom_range(0, 4));
            else
            begin
                vec = 8'($urandom);
                if (vec == VEC_HALT)
                    vec = 8'hFF;
            end
            w[7:0] = vec;
        end
        return w;
    endfunction

    function automatic bit [15:0] data_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) return KBSR_ADDR;
        if (r < 20) return 16'h0000;
        if (r < 25) return KBDR_ADDR;
        return 16'($urandom);
    endfunction

    function automatic bit [15:0] string_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return 16'h0000;
        if (r < 50) return {8'h00, 8'($urandom)};
        return 16'($urandom);
    endfunction

    // Choose the next request: a random load, a load that makes the coming step read
    // only written words, or the step itself.
    task automatic plan(output bit m, output bit [15:0] la, output bit [15:0] lw,
                        output bit kv, output bit [7:0] kc);
        bit [15:0] inst, npc, a, b;
        m = 1;
        la = 16'($urandom);
        lw = 16'($urandom);
        kv = ($urandom_range(0, 3) != 0);
        kc = 8'($urandom);
        if ($urandom_range(0, 99) < 3)
        begin
            m = 0;
            return;
        end
        if (sb.halted || sb.faulted)
            return;
        if (sb.smode != STR_IDLE)
        begin
            if (!sb.wr[sb.sptr])
            begin
                m = 0;
                la = sb.sptr;
                lw = string_word();
            end
            return;
        end
        if (sb.pc == KBSR_ADDR)
        begin
            // fetch of the status word must read zero, a no-op branch
            kv = 0;
            primed = 0;
            return;
        end
        if (!sb.wr[sb.pc] || (!ending && is_terminal(sb.mem[sb.pc])) ||
            (!primed && (ending || $urandom_range(0, 9) < 8)))
        begin
            primed = 1;
            m = 0;
            la = sb.pc;
            lw = ending ? term_word : next_instruction();
            return;
        end
        inst = sb.mem[sb.pc];
        npc = sb.pc + 16'd1;
        a = npc + {{7{inst[8]}}, inst[8:0]};
        b = 16'h0000;
        if (inst[15:12] == OP_LDR)
            a = sb.rf[inst[8:6]] + {{10{inst[5]}}, inst[5:0]};
        if (inst[15:12] inside {OP_LD, OP_LDI, OP_STI, OP_LDR} &&
            a != KBSR_ADDR && !sb.wr[a])
        begin
            m = 0;
            la = a;
            lw = data_word();
            return;
        end
        if (inst[15:12] == OP_LDI)
        begin
            if (a == KBSR_ADDR)
                b = !sb.wr[KBSR_READY] ? KBSR_READY : 16'h0000;
            else
                b = sb.mem[a];
            if (b != KBSR_ADDR && !sb.wr[b])
            begin
                m = 0;
                la = b;
                lw = data_word();
                return;
            end
        end
        primed = 0;
    endtask

    task automatic send_one();
        bit m, kv;
        bit [15:0] la, lw;
        bit [7:0] kc;
        int gap;
        plan(m, la, lw, kv, kc);
        mode <= m;
        load_address <= la;
        load_word <= lw;
        key_valid <= kv;
        key_char <= kc;
        in_valid <= 1;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(m, la, lw, kv, kc);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 20);
            gap = $urandom_range(1, 8);
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_start(bit [15:0] v);
        cfg_wr_en <= 1;
        cfg_wr_data <= v;
        @(posedge clk);
        sb.configure(v);
        cfg_wr_en <= 0;
    endtask

    always @(posedge clk)
    begin
        step_result_t a;
        if (rst_n && out_valid && !out_stall)
        begin
            a.cv = char_valid; a.ch = char_out; a.ret = retired; a.wk = waiting_key;
            a.stp = stopped; a.flt = fault; a.pc = pc_now;
            sb.check(a);
        end
    end

    // receiver stall pattern, with one long hold to back up the core
    initial
    begin
        int cyc, hold, pat;
        cyc = 0;
        hold = 0;
        pat = 0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc == 1500)
                hold = 300;
            if (cyc % 64 == 0)
                pat = $urandom_range(0, 2);
            if (hold > 0)
            begin
                hold--;
                out_stall <= 1;
            end
            else if (pat == 1)
                out_stall <= ($urandom_range(0, 9) < 3);
            else if (pat == 2)
                out_stall <= (cyc % 3 == 0);
            else
                out_stall <= 0;
        end
    end

    initial
    begin
        bit [15:0] starts[5];
        int pick;
        starts = '{PC_RESET, 16'h0000, 16'hFFFF, 16'h0000, PC_RESET};
        starts[3] = 16'($urandom);
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        for (int p = 0; p < 5; p++)
        begin
            if (p > 0)
            begin
                drain();
                write_start(starts[p]);
            end
            repeat (290) send_one();
        end
        pick = $urandom_range(0, 2);
        term_word = (pick == 0) ? {OP_TRAP, 4'h0, VEC_HALT} :
                    (pick == 1) ? {OP_RTI, 12'h000} : {OP_RES, 12'h000};
        ending = 1;
        repeat (15) send_one();
        drain();
        if (sb.errors == 0)
            $display("lc3_instruction_core: match");
        else
            $display("lc3_instruction_core: mismatch");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("lc3_instruction_core: mismatch");
        $finish;
    end

endmodule

/* lc3_instruction_core.f */
design/lc3_pkg.sv
design/lc3_ctrl.sv
design/lc3_datapath.sv
design/lc3_instruction_core.sv
tb/sv/lc3_instruction_core_tb.sv
